// ===== src/pid_pkg.sv =====
// Shared types, codes and saturating arithmetic helpers for the PID controller.
// Used by pid_cfg_regs, pid_step and pid_controller_anti_windup_unit; depends on nothing.
package pid_pkg;

	// Fixed field widths.
	localparam int ERR_W   = 16;          // error sample width
	localparam int OP_W    = ERR_W + 1;   // error sum / difference width
	localparam int COEF_W  = 32;          // Q16.16 coefficient width
	localparam int PROD_W  = COEF_W + OP_W;
	localparam int WIDE_W  = 66;          // holds any product before saturation
	localparam int ACC_W   = 64;          // saturated sum width
	localparam int INTEG_W = 48;          // integrator width
	localparam int OUT_W   = 16;          // drive and limit width
	localparam int IDX_W   = 3;           // register index width
	localparam int MODE_W  = 3;

	// Mode codes; codes above MODE_PID behave as PID.
	localparam logic [MODE_W-1:0] MODE_P   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_I   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PD  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PI  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PID = 3'd4;

	// Register indexes.
	localparam logic [IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd1;
	localparam logic [IDX_W-1:0] REG_INTEG_COEFF = 3'd2;
	localparam logic [IDX_W-1:0] REG_DERIV_COEFF = 3'd3;
	localparam logic [IDX_W-1:0] REG_OUT_MAX     = 3'd4;
	localparam logic [IDX_W-1:0] REG_OUT_MIN     = 3'd5;

	// Action codes.
	localparam logic ACT_STEP  = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	typedef struct packed {
		logic                     action;
		logic signed [ERR_W-1:0]  error_in;
	} req_t;

	typedef struct packed {
		logic signed [OUT_W-1:0]  drive_out;
		logic                     clamped;
		logic                     windup_hold;
	} rsp_t;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [COEF_W-1:0] prop_gain;
		logic signed [COEF_W-1:0] integ_coeff;
		logic signed [COEF_W-1:0] deriv_coeff;
		logic signed [OUT_W-1:0]  out_max;
		logic signed [OUT_W-1:0]  out_min;
	} cfg_t;

	typedef struct packed {
		logic signed [INTEG_W-1:0] integrator;
		logic signed [ERR_W-1:0]   prev_error;
		logic                      windup_flag;
	} state_t;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Saturate a wide value to the signed 64-bit range.
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] w);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = {{(WIDE_W-ACC_W){1'b0}}, ACC_MAX};
		lo = {{(WIDE_W-ACC_W){1'b1}}, ACC_MIN};
		if (w > hi) begin
			return ACC_MAX;
		end else if (w < lo) begin
			return ACC_MIN;
		end
		return w[ACC_W-1:0];
	endfunction

	// Saturating signed 64-bit add.
	function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

	// Exact coefficient times operand, saturated to 64 bits.
	function automatic logic signed [ACC_W-1:0] mul_sat(input logic signed [COEF_W-1:0] c,
			input logic signed [OP_W-1:0] op);
		logic signed [PROD_W-1:0] p;
		p = c * op;
		return sat_acc({{(WIDE_W-PROD_W){p[PROD_W-1]}}, p});
	endfunction

	// Clamp a 64-bit value to the signed 48-bit integrator range.
	function automatic logic signed [INTEG_W-1:0] clamp_integ(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = {{(ACC_W-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}};
		lo = {{(ACC_W-INTEG_W+1){1'b1}}, {(INTEG_W-1){1'b0}}};
		if (v > hi) begin
			return hi[INTEG_W-1:0];
		end else if (v < lo) begin
			return lo[INTEG_W-1:0];
		end
		return v[INTEG_W-1:0];
	endfunction

endpackage

// ===== src/pid_controller_anti_windup_unit.sv =====
// Top level of the discrete PID controller with trapezoidal integration and anti-windup.
// Instantiates pid_cfg_regs and pid_step; depends on pid_pkg.

// The block takes one request per clock unless the response side stalls: an error
// sample to run one control step, or a clear. Every request gives exactly one response
// with the clamped drive, the clamp flag and the windup flag after the step. A request
// is latched into an input register, the whole step (three 32x17 products, the
// saturating integrator and term sum, the limit compare) runs combinationally from that
// register, and the controller state and the response register are loaded together at
// the end of it; a result thus passes the input register, then the response register.
// With the response taken every cycle a new request is accepted every cycle. The
// register-to-register path through integrator, term sum, compare and windup flag sets
// the clock rate. The user must write mode, gains and limits through the configuration
// port only while no request is in flight; the block itself does not enforce it. P mode
// (0), I (1), PD (2), PI (3) and PID (4 and above) are supported, and a clear zeros
// output, previous error and integrator but keeps the windup flag.
module pid_controller_anti_windup_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  pid_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output pid_pkg::rsp_t                  rsp,
	input  logic                           cfg_we,
	input  logic [pid_pkg::IDX_W-1:0]      cfg_index,
	input  logic [pid_pkg::COEF_W-1:0]     cfg_wdata
);

	pid_pkg::cfg_t   cfg;
	pid_pkg::req_t   req_s1;
	logic            valid_s1;
	pid_pkg::state_t state_q;
	pid_pkg::state_t state_next;
	pid_pkg::rsp_t   rsp_next;
	pid_pkg::rsp_t   rsp_q;
	logic            rsp_valid_q;
	logic            advance;
	logic            accept;

	pid_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pid_step #(
		.FRAC_BITS (FRAC_BITS)
	) u_step (
		.cfg        (cfg),
		.state      (state_q),
		.req        (req_s1),
		.state_next (state_next),
		.rsp        (rsp_next)
	);

	// Advance the latched request when the response register is free or being emptied.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign accept    = req_valid && req_ready;

	// Input register: hold the request until its step completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// Controller state: update only when a step completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Response register: load on a completed step, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== src/pid_cfg_regs.sv =====
// Configuration register file of the PID controller: mode, gains and output limits.
// Depends on pid_pkg for the register indexes and the cfg_t type.
module pid_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pid_pkg::IDX_W-1:0]           cfg_index,
	input  logic [pid_pkg::COEF_W-1:0]          cfg_wdata,
	output pid_pkg::cfg_t                       cfg
);

	pid_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= pid_pkg::MODE_PID;
			cfg_q.prop_gain   <= '0;
			cfg_q.integ_coeff <= '0;
			cfg_q.deriv_coeff <= '0;
			cfg_q.out_max     <= {1'b0, {(pid_pkg::OUT_W-1){1'b1}}};
			cfg_q.out_min     <= {1'b1, {(pid_pkg::OUT_W-1){1'b0}}};
		end else if (cfg_we) begin
			case (cfg_index)
				pid_pkg::REG_MODE:        cfg_q.mode        <= cfg_wdata[pid_pkg::MODE_W-1:0];
				pid_pkg::REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_wdata;
				pid_pkg::REG_INTEG_COEFF: cfg_q.integ_coeff <= cfg_wdata;
				pid_pkg::REG_DERIV_COEFF: cfg_q.deriv_coeff <= cfg_wdata;
				pid_pkg::REG_OUT_MAX:     cfg_q.out_max     <= cfg_wdata[pid_pkg::OUT_W-1:0];
				pid_pkg::REG_OUT_MIN:     cfg_q.out_min     <= cfg_wdata[pid_pkg::OUT_W-1:0];
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/pid_step.sv =====
// One control step of the PID controller as combinational logic: integrator update,
// term sum, clamp and windup decision. Depends on pid_pkg.
module pid_step #(
	parameter int FRAC_BITS = 16
) (
	input  pid_pkg::cfg_t   cfg,
	input  pid_pkg::state_t state,
	input  pid_pkg::req_t   req,
	output pid_pkg::state_t state_next,
	output pid_pkg::rsp_t   rsp
);

	localparam int ACC_W = pid_pkg::ACC_W;

	logic                               use_p;
	logic                               use_i;
	logic                               use_d;
	logic signed [pid_pkg::ERR_W-1:0]   e;
	logic signed [pid_pkg::OP_W-1:0]    e_sum;
	logic signed [pid_pkg::OP_W-1:0]    e_diff;
	logic signed [ACC_W-1:0]            integ_ext;
	logic signed [pid_pkg::INTEG_W-1:0] integ_upd;
	logic signed [pid_pkg::INTEG_W-1:0] integ_new;
	logic signed [ACC_W-1:0]            p_term;
	logic signed [ACC_W-1:0]            u_pd;
	logic signed [ACC_W-1:0]            u;
	logic signed [ACC_W-1:0]            hi;
	logic signed [ACC_W-1:0]            lo;
	logic signed [ACC_W-1:0]            u_floor;
	logic                               over;
	logic                               under;
	logic                               e_pos;
	logic                               e_neg;

	assign use_p = (cfg.mode != pid_pkg::MODE_I);
	assign use_i = (cfg.mode == pid_pkg::MODE_I) || (cfg.mode >= pid_pkg::MODE_PI);
	assign use_d = (cfg.mode == pid_pkg::MODE_PD) || (cfg.mode >= pid_pkg::MODE_PID);

	assign e      = req.error_in;
	assign e_sum  = {e[pid_pkg::ERR_W-1], e} +
		{state.prev_error[pid_pkg::ERR_W-1], state.prev_error};
	assign e_diff = {e[pid_pkg::ERR_W-1], e} -
		{state.prev_error[pid_pkg::ERR_W-1], state.prev_error};

	assign integ_ext = {{(ACC_W-pid_pkg::INTEG_W){state.integrator[pid_pkg::INTEG_W-1]}},
		state.integrator};
	assign integ_upd = pid_pkg::clamp_integ(pid_pkg::sat_add(integ_ext,
		pid_pkg::mul_sat(cfg.integ_coeff, e_sum)));
	assign integ_new = (use_i && !state.windup_flag) ? integ_upd : state.integrator;

	// Sum in the fixed order P, D, I with saturation after each add.
	assign p_term = use_p ? pid_pkg::mul_sat(cfg.prop_gain,
		{e[pid_pkg::ERR_W-1], e}) : '0;
	assign u_pd   = use_d ? pid_pkg::sat_add(p_term,
		pid_pkg::mul_sat(cfg.deriv_coeff, e_diff)) : p_term;
	assign u      = use_i ? pid_pkg::sat_add(u_pd,
		{{(ACC_W-pid_pkg::INTEG_W){integ_new[pid_pkg::INTEG_W-1]}}, integ_new}) : u_pd;

	assign hi = {{(ACC_W-pid_pkg::OUT_W){cfg.out_max[pid_pkg::OUT_W-1]}}, cfg.out_max}
		<<< FRAC_BITS;
	assign lo = {{(ACC_W-pid_pkg::OUT_W){cfg.out_min[pid_pkg::OUT_W-1]}}, cfg.out_min}
		<<< FRAC_BITS;
	assign over    = u > hi;
	assign under   = u < lo;
	assign u_floor = u >>> FRAC_BITS;

	assign e_neg = e[pid_pkg::ERR_W-1];
	assign e_pos = !e_neg && (e != '0);

	always_comb begin
		state_next = state;
		rsp        = '0;
		if (req.action == pid_pkg::ACT_CLEAR) begin
			state_next.integrator = '0;
			state_next.prev_error = '0;
			rsp.windup_hold       = state.windup_flag;
		end else begin
			state_next.integrator = integ_new;
			if (use_i) begin
				state_next.windup_flag = (e_pos && over) || (e_neg && under);
			end
			if (cfg.mode != pid_pkg::MODE_P) begin
				state_next.prev_error = e;
			end
			if (over) begin
				rsp.drive_out = cfg.out_max;
			end else if (under) begin
				rsp.drive_out = cfg.out_min;
			end else begin
				rsp.drive_out = u_floor[pid_pkg::OUT_W-1:0];
			end
			rsp.clamped     = over || under;
			rsp.windup_hold = state_next.windup_flag;
		end
	end

endmodule

// ===== tb/pid_controller_anti_windup_unit_test.sv =====
// Self-checking testbench for pid_controller_anti_windup_unit: directed power-on, mode,
// windup and saturation cases, then random traffic under random idling on both handshakes.
// Depends on pid_pkg and the controller RTL only.
module pid_controller_anti_windup_unit_test;

	localparam int FRAC = 16;
	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic signed [127:0] SUM_TOP = (128'sd1 <<< 63) - 128'sd1;
	localparam logic signed [127:0] SUM_BOT = -(128'sd1 <<< 63);
	localparam logic signed [127:0] INTEG_TOP = (128'sd1 <<< 47) - 128'sd1;
	localparam logic signed [127:0] INTEG_BOT = -(128'sd1 <<< 47);

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	pid_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	pid_pkg::rsp_t rsp;
	logic cfg_we;
	logic [pid_pkg::IDX_W-1:0] cfg_index;
	logic [pid_pkg::COEF_W-1:0] cfg_wdata;

	// Controller settings as last written, with their reset values.
	logic [pid_pkg::MODE_W-1:0] ctl_mode = pid_pkg::MODE_PID;
	logic signed [31:0] kp = '0;
	logic signed [31:0] ki_half = '0;
	logic signed [31:0] kd_rate = '0;
	logic signed [15:0] drive_hi = 16'sh7FFF;
	logic signed [15:0] drive_lo = -16'sh8000;

	// Controller history as the predictor tracks it.
	logic signed [47:0] integ_acc = '0;
	logic signed [15:0] last_err = '0;
	logic hold_flag = 1'b0;

	// Responses owed by the block, oldest first.
	pid_pkg::rsp_t drive_due[$];
	int unsigned idle_pct;
	int unsigned stall_pct;
	int errors = 0;
	int responses_seen = 0;

	always #2 clk = ~clk;

	pid_controller_anti_windup_unit #(.FRAC_BITS(FRAC)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Saturate to the signed 64-bit range.
	function automatic logic signed [127:0] clip64(input logic signed [127:0] v);
		if (v > SUM_TOP) return SUM_TOP;
		if (v < SUM_BOT) return SUM_BOT;
		return v;
	endfunction

	// Advance the predicted controller by one request and return the response it owes.
	function automatic pid_pkg::rsp_t predict_drive(input pid_pkg::req_t r);
		pid_pkg::rsp_t res;
		logic signed [15:0] e16;
		logic signed [127:0] err;
		logic signed [127:0] acc;
		logic signed [127:0] upper;
		logic signed [127:0] lower;
		logic signed [127:0] whole;
		logic use_p, use_i, use_d, over, under;
		res = '0;
		if (r.action == pid_pkg::ACT_CLEAR) begin
			// Clear history but keep the windup flag.
			integ_acc = '0;
			last_err = '0;
			res.windup_hold = hold_flag;
			return res;
		end
		e16 = r.error_in;
		err = e16;
		use_p = (ctl_mode != pid_pkg::MODE_I);
		use_i = (ctl_mode == pid_pkg::MODE_I) || (ctl_mode >= pid_pkg::MODE_PI);
		use_d = (ctl_mode == pid_pkg::MODE_PD) || (ctl_mode >= pid_pkg::MODE_PID);

		// Trapezoidal integration, frozen while the windup flag holds.
		if (use_i && !hold_flag) begin
			acc = clip64(integ_acc + clip64(ki_half * (err + last_err)));
			if (acc > INTEG_TOP) acc = INTEG_TOP;
			if (acc < INTEG_BOT) acc = INTEG_BOT;
			integ_acc = acc[47:0];
		end

		acc = '0;
		if (use_p) acc = clip64(acc + clip64(kp * err));
		if (use_d) acc = clip64(acc + clip64(kd_rate * (err - last_err)));
		if (use_i) acc = clip64(acc + integ_acc);

		upper = drive_hi;
		upper = upper <<< FRAC;
		lower = drive_lo;
		lower = lower <<< FRAC;
		over = acc > upper;
		under = acc < lower;

		// Upper limit takes priority; otherwise round toward minus infinity.
		if (over) begin
			res.drive_out = drive_hi;
		end else if (under) begin
			res.drive_out = drive_lo;
		end else begin
			whole = acc >>> FRAC;
			res.drive_out = whole[15:0];
		end

		if (use_i) hold_flag = (err > 0 && over) || (err < 0 && under);
		if (ctl_mode != pid_pkg::MODE_P) last_err = e16;
		res.clamped = over || under;
		res.windup_hold = hold_flag;
		return res;
	endfunction

	// Track register writes, predict each accepted request and check each response.
	always @(posedge clk) begin
		pid_pkg::rsp_t want;
		if (cfg_we) begin
			case (cfg_index)
				pid_pkg::REG_MODE:        ctl_mode = cfg_wdata[pid_pkg::MODE_W-1:0];
				pid_pkg::REG_PROP_GAIN:   kp = cfg_wdata;
				pid_pkg::REG_INTEG_COEFF: ki_half = cfg_wdata;
				pid_pkg::REG_DERIV_COEFF: kd_rate = cfg_wdata;
				pid_pkg::REG_OUT_MAX:     drive_hi = cfg_wdata[15:0];
				pid_pkg::REG_OUT_MIN:     drive_lo = cfg_wdata[15:0];
				default: ;
			endcase
		end
		if (req_valid && req_ready) drive_due.push_back(predict_drive(req));
		if (rsp_valid && rsp_ready) begin
			responses_seen++;
			if (drive_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("response %0d with nothing owed: drive %0d clamped %b hold %b",
						responses_seen, $signed(rsp.drive_out), rsp.clamped, rsp.windup_hold);
			end else begin
				want = drive_due.pop_front();
				if (rsp.drive_out !== want.drive_out || rsp.clamped !== want.clamped ||
						rsp.windup_hold !== want.windup_hold) begin
					errors++;
					if (errors <= 10)
						$display("response %0d: drive %0d/%0d clamped %b/%b hold %b/%b %s",
							responses_seen, $signed(want.drive_out), $signed(rsp.drive_out),
							want.clamped, rsp.clamped, want.windup_hold, rsp.windup_hold,
							"(expected/actual)");
				end
			end
		end
	end

	// Stall the response side at random.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Idle at random, then hold one request until it is taken.
	task automatic send_request(input logic act, input logic [15:0] err);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{action: act, error_in: err};
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	// Drop valid and hold until every owed response has arrived.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (drive_due.size() != 0) @(posedge clk);
	endtask

	// Leaves the write enable high; load_settings lowers it.
	task automatic write_reg(input logic [pid_pkg::IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Write every register, then poke the unused indexes, which must change nothing.
	task automatic load_settings(input logic [31:0] m, input logic [31:0] p_gain,
			input logic [31:0] i_gain, input logic [31:0] d_gain,
			input logic [31:0] top, input logic [31:0] bot);
		write_reg(pid_pkg::REG_MODE, m);
		write_reg(pid_pkg::REG_PROP_GAIN, p_gain);
		write_reg(pid_pkg::REG_INTEG_COEFF, i_gain);
		write_reg(pid_pkg::REG_DERIV_COEFF, d_gain);
		write_reg(pid_pkg::REG_OUT_MAX, top);
		write_reg(pid_pkg::REG_OUT_MIN, bot);
		for (int i = pid_pkg::REG_OUT_MIN + 1; i < (1 << pid_pkg::IDX_W); i++)
			write_reg(i[pid_pkg::IDX_W-1:0], $urandom);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4, 5: return $urandom_range(262144) - 131072;
			6, 7, 8: return $urandom_range(32768) - 16384;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_error();
		logic [31:0] v;
		case ($urandom_range(9))
			0: v = 32'h7FFF;
			1: v = 32'h8000;
			2: v = 32'h0;
			3, 4, 5: v = $urandom_range(600) - 300;
			default: v = $urandom;
		endcase
		return v[15:0];
	endfunction

	// Zero gains from reset: every step drives zero, whatever the error.
	task automatic test_power_on();
		send_request(pid_pkg::ACT_STEP, 16'h7FFF);
		send_request(pid_pkg::ACT_STEP, 16'h8000);
	endtask

	// Walk every mode code, the spare codes too, with all three gains nonzero.
	task automatic test_mode_select();
		for (int m = 0; m < (1 << pid_pkg::MODE_W); m++) begin
			wait_drained();
			load_settings(m, ONE_Q16, ONE_Q16 / 4, ONE_Q16 / 2, 32767, -32768);
			send_request(pid_pkg::ACT_STEP, 16'((m % 2) ? -16'sd250 - m : 16'sd1000 + m));
		end
	endtask

	// Drive past the limits so the flag sets, freezes the integrator and survives a clear.
	task automatic test_windup_hold();
		wait_drained();
		load_settings(pid_pkg::MODE_PI, 2 * ONE_Q16, ONE_Q16, 0, 100, -100);
		send_request(pid_pkg::ACT_CLEAR, 16'h0);
		send_request(pid_pkg::ACT_STEP, 16'd200);
		send_request(pid_pkg::ACT_STEP, 16'd200);
		send_request(pid_pkg::ACT_CLEAR, 16'h0);
		send_request(pid_pkg::ACT_STEP, -16'sd300);
		send_request(pid_pkg::ACT_STEP, -16'sd300);
		// Crossed limits: the upper test decides first.
		wait_drained();
		load_settings(pid_pkg::MODE_PID, ONE_Q16, ONE_Q16, ONE_Q16, -10, 10);
		send_request(pid_pkg::ACT_STEP, 16'd5);
	endtask

	// Run the integrator into both rails with the most negative coefficient.
	task automatic test_saturation();
		wait_drained();
		load_settings(pid_pkg::MODE_I, 0, 32'h8000_0000, 0, 32767, -32768);
		send_request(pid_pkg::ACT_CLEAR, 16'h0);
		repeat (3) send_request(pid_pkg::ACT_STEP, 16'h7FFF);
		send_request(pid_pkg::ACT_CLEAR, 16'h0);
		repeat (2) send_request(pid_pkg::ACT_STEP, 16'h8000);
		wait_drained();
		load_settings(pid_pkg::MODE_P, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32767, -32768);
		send_request(pid_pkg::ACT_STEP, 16'h8000);
	endtask

	// Random settings per phase, random requests within; one phase runs without idling,
	// and odd phases pause the sender midway until everything owed has come back.
	task automatic test_random_traffic();
		logic signed [15:0] a, b, top, bot;
		logic [31:0] pad;
		for (int phase = 0; phase < 10; phase++) begin
			wait_drained();
			case ($urandom_range(7))
				0: begin
					top = 16'sh7FFF;
					bot = -16'sh8000;
				end
				1: begin
					top = 16'(-$urandom_range(200));
					bot = 16'($urandom_range(200));
				end
				2, 3, 4: begin
					a = 16'($urandom_range(4000) - 2000);
					b = 16'($urandom_range(4000) - 2000);
					top = (a > b) ? a : b;
					bot = (a > b) ? b : a;
				end
				default: begin
					a = 16'($urandom);
					b = 16'($urandom);
					top = (a > b) ? a : b;
					bot = (a > b) ? b : a;
				end
			endcase
			pad = $urandom;
			load_settings($urandom, pick_gain(), pick_gain(), pick_gain(),
				{pad[31:16], top}, {pad[15:0], bot});
			idle_pct = (phase == 4) ? 0 : 34;
			stall_pct = idle_pct;
			for (int n = 0; n < 104; n++) begin
				if (n == 52 && phase % 2 == 1) wait_drained();
				send_request(($urandom_range(99) < 6) ? pid_pkg::ACT_CLEAR : pid_pkg::ACT_STEP,
					pick_error());
			end
		end
		idle_pct = 34;
		stall_pct = 34;
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_pct = 34;
		stall_pct = 34;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on();
		test_mode_select();
		test_windup_hold();
		test_saturation();
		test_random_traffic();

		// Drain, then give the pipeline time to show any stray response.
		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0 && drive_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Bound the run well beyond the slowest correct one.
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
